// ===== src/bdgt_pkg.sv =====
// Box distance grid table: shared widths, limits, codes and unit request types.
// No dependencies; imported by the interfaces and every module of the block.
`default_nettype none
package bdgt_pkg;

  localparam int MAX_COLUMNS      = 64;
  localparam int MAX_ROWS         = 64;
  localparam int SAMPLES_PER_CELL = 10;
  localparam int STORE_DEPTH      = MAX_COLUMNS * MAX_ROWS;
  localparam int ADDR_W           = $clog2(STORE_DEPTH);
  localparam int IDX_W            = $clog2(MAX_COLUMNS);

  localparam int CELL_W = 16;   // cell_size register
  localparam int BOX_W  = 20;   // box and margin registers
  localparam int S_W    = 17;   // cell size in half units
  localparam int EXT_W  = 22;   // half extent plus margin in half units
  localparam int DVD_W  = 26;   // divider dividend and quotient
  localparam int Q_W    = 24;   // query coordinates
  localparam int CTR_W  = 24;   // grid centre in half units
  localparam int CNT_W  = 7;    // reported column and row counts
  localparam int DIST_W = 24;   // stored distance
  localparam int MAG_W  = 22;   // per-axis worst distance
  localparam int SQ_W   = 44;   // square root operand
  localparam int ROOT_W = SQ_W / 2;

  localparam logic [1:0] STATUS_OK        = 2'd0;
  localparam logic [1:0] STATUS_NOT_BUILT = 2'd1;
  localparam logic [1:0] STATUS_OOB       = 2'd2;
  localparam logic [1:0] STATUS_TOO_LARGE = 2'd3;

  localparam logic OP_BUILD  = 1'b0;
  localparam logic OP_LOOKUP = 1'b1;

  localparam logic [1:0] REG_CELL_SIZE  = 2'd0;
  localparam logic [1:0] REG_BOX_WIDTH  = 2'd1;
  localparam logic [1:0] REG_BOX_HEIGHT = 2'd2;
  localparam logic [1:0] REG_MARGIN     = 2'd3;

  typedef struct packed {
    logic             start;
    logic [DVD_W-1:0] dividend;
    logic [S_W-1:0]   divisor;
  } div_req_t;

  typedef struct packed {
    logic             done;
    logic [DVD_W-1:0] quotient;
    logic [S_W-1:0]   remainder;
  } div_rsp_t;

  typedef struct packed {
    logic            start;
    logic [SQ_W-1:0] operand;
  } sqrt_req_t;

  typedef struct packed {
    logic              done;
    logic [ROOT_W-1:0] root;
  } sqrt_rsp_t;

endpackage
`default_nettype wire

// ===== src/bdgt_in_if.sv =====
// Input channel of the box distance grid table: valid/ready plus item fields.
// Depends on bdgt_pkg.
`default_nettype none
interface bdgt_in_if
  import bdgt_pkg::*;
;
  logic           valid;
  logic           ready;
  logic           opcode;
  logic [Q_W-1:0] query_x;
  logic [Q_W-1:0] query_y;

  modport source (output valid, opcode, query_x, query_y, input ready);
  modport sink   (input valid, opcode, query_x, query_y, output ready);
endinterface
`default_nettype wire

// ===== src/bdgt_out_if.sv =====
// Result channel of the box distance grid table: valid/ready plus result fields.
// Depends on bdgt_pkg.
`default_nettype none
interface bdgt_out_if
  import bdgt_pkg::*;
;
  logic              valid;
  logic              ready;
  logic [1:0]        status;
  logic [DIST_W-1:0] distance;
  logic [CNT_W-1:0]  cells_across;
  logic [CNT_W-1:0]  cells_down;

  modport source (output valid, status, distance, cells_across, cells_down, input ready);
  modport sink   (input valid, status, distance, cells_across, cells_down, output ready);
endinterface
`default_nettype wire

// ===== src/bdgt_div.sv =====
// Restoring divider, one quotient bit per cycle.
// Depends on bdgt_pkg.
`default_nettype none
module bdgt_div
  import bdgt_pkg::*;
(
  input  wire logic     clk,
  input  wire logic     rst,
  input  wire div_req_t req,
  output div_rsp_t      rsp
);
  localparam int CW = $clog2(DVD_W + 1);

  logic             busy;
  logic [CW-1:0]    cnt;
  logic [DVD_W-1:0] quo;
  logic [S_W-1:0]   rem;
  logic [S_W-1:0]   den;
  logic             done;
  logic [S_W:0]     trial;

  assign trial = {rem, quo[DVD_W-1]};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        busy <= 1'b1;
        cnt  <= '0;
        quo  <= req.dividend;
        den  <= req.divisor;
        rem  <= '0;
      end else if (busy) begin
        if (trial >= {1'b0, den}) begin
          rem <= S_W'(trial - {1'b0, den});
          quo <= {quo[DVD_W-2:0], 1'b1};
        end else begin
          rem <= trial[S_W-1:0];
          quo <= {quo[DVD_W-2:0], 1'b0};
        end
        cnt <= cnt + 1'b1;
        if (cnt == CW'(DVD_W - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  assign rsp.done      = done;
  assign rsp.quotient  = quo;
  assign rsp.remainder = rem;
endmodule
`default_nettype wire

// ===== src/bdgt_sqrt.sv =====
// Digit-by-digit integer square root, one root bit per cycle (floor result).
// Depends on bdgt_pkg.
`default_nettype none
module bdgt_sqrt
  import bdgt_pkg::*;
(
  input  wire logic      clk,
  input  wire logic      rst,
  input  wire sqrt_req_t req,
  output sqrt_rsp_t      rsp
);
  localparam int CW  = $clog2(ROOT_W + 1);
  localparam int RMW = ROOT_W + 4;

  logic              busy;
  logic              done;
  logic [CW-1:0]     cnt;
  logic [SQ_W-1:0]   op;
  logic [RMW-1:0]    rem;
  logic [ROOT_W-1:0] root;
  logic [RMW-1:0]    rem_sh;
  logic [RMW-1:0]    trial;

  assign rem_sh = {rem[RMW-3:0], op[SQ_W-1 -: 2]};
  assign trial  = RMW'({root, 2'b01});

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        busy <= 1'b1;
        cnt  <= '0;
        op   <= req.operand;
        rem  <= '0;
        root <= '0;
      end else if (busy) begin
        if (rem_sh >= trial) begin
          rem  <= rem_sh - trial;
          root <= {root[ROOT_W-2:0], 1'b1};
        end else begin
          rem  <= rem_sh;
          root <= {root[ROOT_W-2:0], 1'b0};
        end
        op  <= {op[SQ_W-3:0], 2'b00};
        cnt <= cnt + 1'b1;
        if (cnt == CW'(ROOT_W - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  assign rsp.done = done;
  assign rsp.root = root;
endmodule
`default_nettype wire

// ===== src/box_distance_grid_table.sv =====
// Box distance grid table, top level. One item at a time; ready only when idle.
// Lookup: up to two passes through the bit-serial divider, one per axis.
// Rebuild: setup divides (per axis extent mod cell and count, then step), one sample per
//   cycle per axis, then per cell multiplier + 22-step square root if sampled, else zero.
// Reset (rst, synchronous): no table, zero counts, cell_size 256, other registers 0.
// Distance store needs no clearing: only cells written by the last rebuild are read.
`default_nettype none
module box_distance_grid_table
  import bdgt_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst,
  bdgt_in_if.sink          in_ch,
  bdgt_out_if.source       out_ch,
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [3:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic [31:0]      prdata,
  output logic             pready
);
  // sequencer codes
  localparam logic [4:0] S_IDLE  = 5'd0;
  localparam logic [4:0] S_MOD   = 5'd1;   // extent mod cell
  localparam logic [4:0] S_MODW  = 5'd2;
  localparam logic [4:0] S_CNT   = 5'd3;   // cell count
  localparam logic [4:0] S_CNTW  = 5'd4;
  localparam logic [4:0] S_CHK   = 5'd5;   // size check, start step divide
  localparam logic [4:0] S_STPW  = 5'd6;
  localparam logic [4:0] S_SINIT = 5'd7;   // axis sampling
  localparam logic [4:0] S_SRUN  = 5'd8;
  localparam logic [4:0] S_FRD   = 5'd9;   // grid fill
  localparam logic [4:0] S_FMX   = 5'd10;
  localparam logic [4:0] S_FMY   = 5'd11;
  localparam logic [4:0] S_FSQ   = 5'd12;
  localparam logic [4:0] S_FSW   = 5'd13;
  localparam logic [4:0] S_LXS   = 5'd14;  // lookup
  localparam logic [4:0] S_LXW   = 5'd15;
  localparam logic [4:0] S_LYS   = 5'd16;
  localparam logic [4:0] S_LYW   = 5'd17;
  localparam logic [4:0] S_LCHK  = 5'd18;
  localparam logic [4:0] S_LRD   = 5'd19;
  localparam logic [4:0] S_LDAT  = 5'd20;
  localparam logic [4:0] S_DONE  = 5'd21;

  // ---------------- configuration registers ----------------
  logic [CELL_W-1:0] cell_size;
  logic [BOX_W-1:0]  box_width;
  logic [BOX_W-1:0]  box_height;
  logic [BOX_W-1:0]  margin;

  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cell_size  <= CELL_W'(256);
      box_width  <= '0;
      box_height <= '0;
      margin     <= '0;
    end else if (psel && penable && pwrite && pready) begin
      case (paddr[3:2])
        REG_CELL_SIZE:  cell_size  <= pwdata[CELL_W-1:0];
        REG_BOX_WIDTH:  box_width  <= pwdata[BOX_W-1:0];
        REG_BOX_HEIGHT: box_height <= pwdata[BOX_W-1:0];
        REG_MARGIN:     margin     <= pwdata[BOX_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[3:2])
      REG_CELL_SIZE:  prdata = 32'(cell_size);
      REG_BOX_WIDTH:  prdata = 32'(box_width);
      REG_BOX_HEIGHT: prdata = 32'(box_height);
      REG_MARGIN:     prdata = 32'(margin);
      default:        prdata = '0;
    endcase
  end

  // ---------------- state ----------------
  logic [4:0]        state;
  logic              ax;            // 0: x axis, 1: y axis
  logic              built;
  logic [CNT_W-1:0]  cols, rows;
  logic [CTR_W-1:0]  centre_x, centre_y;
  logic [S_W-1:0]    built_cell;

  // build scratch
  logic [S_W-1:0]    off_x, off_y;
  logic [DVD_W-1:0]  cnt_x, cnt_y;
  logic [S_W-1:0]    step;
  logic signed [Q_W-1:0] sx;        // sample position, half units
  logic [CNT_W-1:0]  sc;            // current cell of the sample
  logic [S_W-1:0]    srem;          // position within that cell
  logic [MAG_W-1:0]  cur_max;
  logic [CNT_W-1:0]  hits_x, hits_y;
  logic [IDX_W-1:0]  fi, fj;
  logic [ADDR_W-1:0] fa;
  logic [2*MAG_W-1:0] sqa, sqb;

  // lookup scratch
  logic signed [DVD_W-1:0] vx, vy;
  logic              oob;
  logic [DVD_W-1:0]  xq, yq;
  logic [ADDR_W-1:0] raddr;

  // result
  logic [1:0]        r_status;
  logic [DIST_W-1:0] r_dist;
  logic              out_valid;
  logic [1:0]        out_status;
  logic [DIST_W-1:0] out_dist;
  logic [CNT_W-1:0]  out_cols, out_rows;

  // ---------------- derived values ----------------
  logic [S_W-1:0]   s_cfg;
  logic [EXT_W-1:0] ext_x, ext_y, ext_ax;
  logic [BOX_W-1:0] half_ax;
  logic [S_W-1:0]   off_ax;
  logic [DVD_W-1:0] cnt_ax;
  logic [CNT_W-1:0] cnt7_ax;
  logic [S_W:0]     off_wide;
  logic [S_W-1:0]   off_new;

  assign s_cfg   = {cell_size, 1'b0};
  assign ext_x   = EXT_W'(box_width) + EXT_W'({margin, 1'b0});
  assign ext_y   = EXT_W'(box_height) + EXT_W'({margin, 1'b0});
  assign ext_ax  = ax ? ext_y : ext_x;
  assign half_ax = ax ? box_height : box_width;
  assign off_ax  = ax ? off_y : off_x;
  assign cnt_ax  = ax ? cnt_y : cnt_x;
  assign cnt7_ax = cnt_ax[CNT_W-1:0];

  // centring offset: cell - (ext mod s), folded into [0, s)
  logic [S_W-1:0] dv_rem;
  assign off_wide = ({2'b0, cell_size} < {1'b0, dv_rem}) ?
                    ({2'b0, cell_size} + {1'b0, s_cfg} - {1'b0, dv_rem}) :
                    ({2'b0, cell_size} - {1'b0, dv_rem});
  assign off_new = off_wide[S_W-1:0];

  // sampling datapath
  logic [Q_W-1:0]   s_abs;
  logic [MAG_W-1:0] s_d, s_new;
  logic [S_W:0]     s_sum;
  logic             s_run;
  assign s_abs = sx[Q_W-1] ? Q_W'(-sx) : Q_W'(sx);
  assign s_d   = (s_abs > Q_W'(half_ax)) ? MAG_W'(s_abs - Q_W'(half_ax)) : '0;
  assign s_new = (s_d > cur_max) ? s_d : cur_max;
  assign s_sum = {1'b0, srem} + {1'b0, step};
  assign s_run = (sx < $signed(Q_W'(ext_ax))) && (sc < cnt7_ax);

  // ---------------- shared units ----------------
  div_req_t  dreq;
  div_rsp_t  drsp;
  sqrt_req_t qreq;
  sqrt_rsp_t qrsp;

  assign dv_rem = drsp.remainder;

  always_comb begin
    dreq.start    = 1'b0;
    dreq.dividend = DVD_W'(ext_ax);
    dreq.divisor  = s_cfg;
    case (state)
      S_MOD: dreq.start = 1'b1;
      S_CNT: begin
        dreq.start    = 1'b1;
        dreq.dividend = DVD_W'(off_ax) + DVD_W'({ext_ax, 1'b0}) + DVD_W'(s_cfg) - DVD_W'(1);
      end
      S_CHK: begin
        dreq.start    = (cnt_x <= DVD_W'(MAX_COLUMNS)) && (cnt_y <= DVD_W'(MAX_ROWS));
        dreq.dividend = DVD_W'(cell_size);
        dreq.divisor  = S_W'(SAMPLES_PER_CELL);
      end
      S_LXS: begin
        dreq.start    = !vx[DVD_W-1];
        dreq.dividend = vx;
        dreq.divisor  = built_cell;
      end
      S_LYS: begin
        dreq.start    = !vy[DVD_W-1];
        dreq.dividend = vy;
        dreq.divisor  = built_cell;
      end
      default: ;
    endcase
  end

  bdgt_div u_div (.clk(clk), .rst(rst), .req(dreq), .rsp(drsp));

  // one multiplier, squares column then row worst distance
  logic [MAG_W-1:0]   colq, rowq, mul_in;
  logic [2*MAG_W-1:0] prod;
  logic [2*MAG_W:0]   sq_sum;
  assign mul_in = (state == S_FMX) ? colq : rowq;
  assign prod   = mul_in * mul_in;
  assign sq_sum = {1'b0, sqa} + {1'b0, sqb};

  assign qreq.start   = (state == S_FSQ);
  assign qreq.operand = SQ_W'(sq_sum[2*MAG_W:2]);

  bdgt_sqrt u_sqrt (.clk(clk), .rst(rst), .req(qreq), .rsp(qrsp));

  // ---------------- memories ----------------
  logic [MAG_W-1:0]  col_max [MAX_COLUMNS];
  logic [MAG_W-1:0]  row_max [MAX_ROWS];
  logic [DIST_W-1:0] dist_mem [STORE_DEPTH];
  logic [DIST_W-1:0] dist_q;
  logic              st_we;
  logic [DIST_W-1:0] st_wd;
  logic              f_hit;

  assign f_hit = ({1'b0, fi} < hits_x) && ({1'b0, fj} < hits_y);
  assign st_we = ((state == S_FRD) && !f_hit) || ((state == S_FSW) && qrsp.done);
  assign st_wd = (state == S_FSW) ? DIST_W'(qrsp.root) : '0;

  always_ff @(posedge clk) begin
    if (state == S_SRUN && s_run && !ax) col_max[sc[IDX_W-1:0]] <= s_new;
    colq <= col_max[fi];
  end

  always_ff @(posedge clk) begin
    if (state == S_SRUN && s_run && ax) row_max[sc[IDX_W-1:0]] <= s_new;
    rowq <= row_max[fj];
  end

  always_ff @(posedge clk) begin
    if (st_we) dist_mem[fa] <= st_wd;
    dist_q <= dist_mem[raddr];
  end

  // fill walk: advance one cell, row-major, address follows
  logic f_last_col, f_last_row;
  assign f_last_col = ({1'b0, fi} == cnt_x[CNT_W-1:0] - CNT_W'(1));
  assign f_last_row = ({1'b0, fj} == cnt_y[CNT_W-1:0] - CNT_W'(1));

  // lookup address; indexes are known in range here
  logic [ADDR_W-1:0] l_addr;
  assign l_addr = ADDR_W'(yq[IDX_W-1:0]) * ADDR_W'(cols) + ADDR_W'(xq[IDX_W-1:0]);

  logic signed [DVD_W-1:0] neg_s;
  assign neg_s = -$signed(DVD_W'(built_cell));

  // ---------------- sequencer ----------------
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      built      <= 1'b0;
      cols       <= '0;
      rows       <= '0;
      centre_x   <= '0;
      centre_y   <= '0;
      built_cell <= '0;
      ax         <= 1'b0;
    end else begin
      case (state)
        S_IDLE: begin
          if (in_ch.valid) begin
            ax       <= 1'b0;
            oob      <= 1'b0;
            r_dist   <= '0;
            r_status <= STATUS_OK;
            if (in_ch.opcode == OP_BUILD) begin
              built <= 1'b0;
              cols  <= '0;
              rows  <= '0;
              if (cell_size == '0) begin
                r_status <= STATUS_TOO_LARGE;
                state    <= S_DONE;
              end else begin
                state <= S_MOD;
              end
            end else if (!built) begin
              r_status <= STATUS_NOT_BUILT;
              state    <= S_DONE;
            end else begin
              vx    <= $signed({{1{in_ch.query_x[Q_W-1]}}, in_ch.query_x, 1'b0}) +
                       $signed(DVD_W'(centre_x));
              vy    <= $signed({{1{in_ch.query_y[Q_W-1]}}, in_ch.query_y, 1'b0}) +
                       $signed(DVD_W'(centre_y));
              state <= S_LXS;
            end
          end
        end

        S_MOD:  state <= S_MODW;
        S_MODW: begin
          if (drsp.done) begin
            if (ax) off_y <= off_new;
            else    off_x <= off_new;
            state <= S_CNT;
          end
        end
        S_CNT:  state <= S_CNTW;
        S_CNTW: begin
          if (drsp.done) begin
            if (ax) begin
              cnt_y    <= drsp.quotient;
              centre_y <= CTR_W'(ext_y) + CTR_W'(off_y);
              state    <= S_CHK;
            end else begin
              cnt_x    <= drsp.quotient;
              centre_x <= CTR_W'(ext_x) + CTR_W'(off_x);
              ax       <= 1'b1;
              state    <= S_MOD;
            end
          end
        end
        S_CHK: begin
          if (dreq.start) begin
            state <= S_STPW;
          end else begin
            centre_x <= '0;
            centre_y <= '0;
            r_status <= STATUS_TOO_LARGE;
            state    <= S_DONE;
          end
        end
        S_STPW: begin
          if (drsp.done) begin
            step  <= (drsp.quotient == '0) ? S_W'(2) : S_W'({drsp.quotient, 1'b0});
            ax    <= 1'b0;
            state <= S_SINIT;
          end
        end

        S_SINIT: begin
          sx      <= -$signed(Q_W'(ext_ax));
          sc      <= '0;
          srem    <= off_ax;
          cur_max <= '0;
          if (ax) hits_y <= '0;
          else    hits_x <= '0;
          state   <= S_SRUN;
        end
        S_SRUN: begin
          if (s_run) begin
            if (ax) hits_y <= sc + CNT_W'(1);
            else    hits_x <= sc + CNT_W'(1);
            sx <= sx + $signed(Q_W'(step));
            if (s_sum >= {1'b0, s_cfg}) begin
              srem    <= S_W'(s_sum - {1'b0, s_cfg});
              sc      <= sc + CNT_W'(1);
              cur_max <= '0;
            end else begin
              srem    <= s_sum[S_W-1:0];
              cur_max <= s_new;
            end
          end else if (!ax) begin
            ax    <= 1'b1;
            state <= S_SINIT;
          end else begin
            fi    <= '0;
            fj    <= '0;
            fa    <= '0;
            state <= S_FRD;
          end
        end

        S_FRD: state <= f_hit ? S_FMX : S_FSW;
        S_FMX: begin
          sqa   <= prod;
          state <= S_FMY;
        end
        S_FMY: begin
          sqb   <= prod;
          state <= S_FSQ;
        end
        S_FSQ: state <= S_FSW;
        S_FSW: begin
          // a cell without samples was written at S_FRD and lands here at once
          if (qrsp.done || !f_hit) begin
            fa <= fa + ADDR_W'(1);
            if (f_last_col) begin
              fi <= '0;
              if (f_last_row) begin
                cols       <= cnt_x[CNT_W-1:0];
                rows       <= cnt_y[CNT_W-1:0];
                built_cell <= s_cfg;
                built      <= 1'b1;
                state      <= S_DONE;
              end else begin
                fj    <= fj + IDX_W'(1);
                state <= S_FRD;
              end
            end else begin
              fi    <= fi + IDX_W'(1);
              state <= S_FRD;
            end
          end
        end

        S_LXS: begin
          if (vx <= neg_s) oob <= 1'b1;
          xq    <= '0;
          state <= vx[DVD_W-1] ? S_LYS : S_LXW;
        end
        S_LXW: begin
          if (drsp.done) begin
            xq    <= drsp.quotient;
            state <= S_LYS;
          end
        end
        S_LYS: begin
          if (vy <= neg_s) oob <= 1'b1;
          yq    <= '0;
          state <= vy[DVD_W-1] ? S_LCHK : S_LYW;
        end
        S_LYW: begin
          if (drsp.done) begin
            yq    <= drsp.quotient;
            state <= S_LCHK;
          end
        end
        S_LCHK: begin
          if (oob || xq >= DVD_W'(cols) || yq >= DVD_W'(rows)) begin
            r_status <= STATUS_OOB;
            state    <= S_DONE;
          end else begin
            raddr <= l_addr;
            state <= S_LRD;
          end
        end
        S_LRD:  state <= S_LDAT;
        S_LDAT: begin
          r_dist <= dist_q;
          state  <= S_DONE;
        end

        S_DONE: begin
          if (!out_valid || out_ch.ready) state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // ---------------- output register ----------------
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (state == S_DONE && (!out_valid || out_ch.ready)) begin
      out_valid  <= 1'b1;
      out_status <= r_status;
      out_dist   <= r_dist;
      out_cols   <= cols;
      out_rows   <= rows;
    end else if (out_ch.ready) begin
      out_valid <= 1'b0;
    end
  end

  assign in_ch.ready         = (state == S_IDLE);
  assign out_ch.valid        = out_valid;
  assign out_ch.status       = out_status;
  assign out_ch.distance     = out_dist;
  assign out_ch.cells_across = out_cols;
  assign out_ch.cells_down   = out_rows;

  // ---------------- checks ----------------
  a_built_counts: assert property (@(posedge clk) disable iff (rst)
    built == (cols != '0))
    else $error("table flag disagrees with column count");

  a_count_limit: assert property (@(posedge clk) disable iff (rst)
    cols <= CNT_W'(MAX_COLUMNS) && rows <= CNT_W'(MAX_ROWS))
    else $error("grid count beyond store limits");

  a_result_source: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(state == S_DONE))
    else $error("result transfer raised outside completion step");

endmodule
`default_nettype wire

// ===== test/tb_top.sv =====
// Self-checking testbench for box_distance_grid_table: directed and random
// build/lookup traffic, APB register writes, and a result predictor.
// Depends on bdgt_pkg, bdgt_in_if, bdgt_out_if and the box_distance_grid_table RTL.
`default_nettype none
module tb_top;
  import bdgt_pkg::*;

  localparam int QUIET_LIMIT = 600000;  // cycles with no transfer at all
  localparam int HOLD_CYCLES = 400;     // receiver hold-off length

  typedef struct packed {
    logic [1:0]        status;
    logic [DIST_W-1:0] distance;
    logic [CNT_W-1:0]  across;
    logic [CNT_W-1:0]  down;
  } grid_result_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic psel, penable, pwrite;
  logic [3:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;

  always #6 clk = ~clk;

  bdgt_in_if  in_ch();
  bdgt_out_if out_ch();

  box_distance_grid_table DUT (
    .clk(clk), .rst(rst), .in_ch(in_ch), .out_ch(out_ch),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  // ---------------------------------------------------------------------------
  // Predictor state: a copy of the registers and of the built table.
  // Lengths are kept in half units (one fraction bit) like the block itself.
  // ---------------------------------------------------------------------------
  logic [CELL_W-1:0] cfg_cell;
  logic [BOX_W-1:0]  cfg_width, cfg_height, cfg_margin;
  bit                tbl_built;
  int                tbl_cols, tbl_rows;
  longint            tbl_ctr_x, tbl_ctr_y, tbl_cell;
  logic [DIST_W-1:0] dist_mem [STORE_DEPTH];
  bit                scan_hit [MAX_COLUMNS];
  longint            scan_max [MAX_COLUMNS];
  bit                col_hit  [MAX_COLUMNS];
  longint            col_max  [MAX_COLUMNS];

  grid_result_t pending_results[$];
  int  mismatches = 0;
  bit  no_idle = 1'b0;      // long stretch without bubbles on either side
  int  hold_requests = 0;   // bumped by a test to make the receiver hold off

  function automatic longint unsigned floor_sqrt(longint unsigned n);
    longint unsigned res, bitv;
    res = 0;
    bitv = 64'd1 << 62;
    while (bitv > n) bitv >>= 2;
    while (bitv != 0) begin
      if (n >= res + bitv) begin
        n -= res + bitv;
        res = (res >> 1) + bitv;
      end else begin
        res >>= 1;
      end
      bitv >>= 2;
    end
    return res;
  endfunction

  // offset and cell count along one axis; ext and s in half units, s > 0
  function automatic void axis_layout(input longint ext, input longint s,
                                      output longint cells, output longint ctr);
    longint off;
    off = s / 2 - ext % s;
    if (off < 0) off += s;
    cells = (off + 2 * ext + s - 1) / s;
    ctr = ext + off;
  endfunction

  // worst distance outside the box per cell along one axis, into scan_hit/scan_max
  function automatic void scan_axis(longint ext, longint half, longint s, longint ctr,
                                    longint cells, longint step);
    longint x, c, a, d;
    for (int k = 0; k < MAX_COLUMNS; k++) begin
      scan_hit[k] = 1'b0;
      scan_max[k] = 0;
    end
    for (x = -ext; x < ext; x += step) begin
      c = (x + ctr) / s;
      a = (x < 0) ? -x : x;
      d = (a > half) ? a - half : 0;
      if (c >= 0 && c < cells) begin
        scan_hit[c] = 1'b1;
        if (d > scan_max[c]) scan_max[c] = d;
      end
    end
  endfunction

  function automatic longint cell_of(longint v, longint s);
    if (v <= -s) return -1;
    return (v >= 0) ? v / s : 0;
  endfunction

  function automatic grid_result_t predict_grid_result(logic op, logic [Q_W-1:0] qx,
                                                       logic [Q_W-1:0] qy);
    grid_result_t r;
    longint s, ex, ey, cx, cy, ctx, cty, step, xi, yi;
    longint unsigned dx, dy;
    r = '0;
    if (op == OP_BUILD) begin
      tbl_built = 1'b0;
      tbl_cols = 0;
      tbl_rows = 0;
      if (cfg_cell == 0) begin
        r.status = STATUS_TOO_LARGE;
      end else begin
        s  = 2 * longint'(cfg_cell);
        ex = longint'(cfg_width) + 2 * longint'(cfg_margin);
        ey = longint'(cfg_height) + 2 * longint'(cfg_margin);
        axis_layout(ex, s, cx, ctx);
        axis_layout(ey, s, cy, cty);
        if (cx > MAX_COLUMNS || cy > MAX_ROWS) begin
          r.status = STATUS_TOO_LARGE;
        end else begin
          step = longint'(cfg_cell) / SAMPLES_PER_CELL;
          if (step < 1) step = 1;
          step *= 2;
          scan_axis(ex, cfg_width, s, ctx, cx, step);
          col_hit = scan_hit;
          col_max = scan_max;
          scan_axis(ey, cfg_height, s, cty, cy, step);
          for (int j = 0; j < cy; j++) begin
            for (int i = 0; i < cx; i++) begin
              if (col_hit[i] && scan_hit[j]) begin
                dx = col_max[i];
                dy = scan_max[j];
                dist_mem[j * cx + i] = DIST_W'(floor_sqrt((dx * dx + dy * dy) >> 2));
              end else begin
                dist_mem[j * cx + i] = '0;
              end
            end
          end
          tbl_cols  = cx;
          tbl_rows  = cy;
          tbl_ctr_x = ctx;
          tbl_ctr_y = cty;
          tbl_cell  = s;
          tbl_built = 1'b1;
          r.status  = STATUS_OK;
        end
      end
    end else if (!tbl_built) begin
      r.status = STATUS_NOT_BUILT;
    end else begin
      xi = cell_of(2 * longint'($signed(qx)) + tbl_ctr_x, tbl_cell);
      yi = cell_of(2 * longint'($signed(qy)) + tbl_ctr_y, tbl_cell);
      if (xi < 0 || xi >= tbl_cols || yi < 0 || yi >= tbl_rows) r.status = STATUS_OOB;
      else r.distance = dist_mem[yi * tbl_cols + xi];
    end
    r.across = CNT_W'(tbl_cols);
    r.down   = CNT_W'(tbl_rows);
    return r;
  endfunction

  // ---------------------------------------------------------------------------
  // Sender side
  // ---------------------------------------------------------------------------
  // Offer one item; returns right after the transfer with valid still high so
  // back-to-back items never drop and raise valid in the same step.
  task automatic send_item(logic op, logic [Q_W-1:0] qx, logic [Q_W-1:0] qy);
    if (!no_idle && $urandom_range(99) < 37) begin
      in_ch.valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < 37);
    end
    in_ch.valid   <= 1'b1;
    in_ch.opcode  <= op;
    in_ch.query_x <= qx;
    in_ch.query_y <= qy;
    do @(posedge clk); while (!in_ch.ready);
    pending_results.push_back(predict_grid_result(op, qx, qy));
  endtask

  task automatic lookup(int x, int y);
    send_item(OP_LOOKUP, Q_W'(x), Q_W'(y));
  endtask

  task automatic rebuild();
    send_item(OP_BUILD, Q_W'($urandom), Q_W'($urandom));
  endtask

  // every item answers, so an empty queue means the block is idle
  task automatic drain();
    in_ch.valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
  endtask

  // APB write: setup then access; the register takes the value at the access edge
  task automatic reg_write(logic [1:0] idx, int unsigned val);
    @(posedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= val;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    case (idx)
      REG_CELL_SIZE:  cfg_cell   = CELL_W'(val);
      REG_BOX_WIDTH:  cfg_width  = BOX_W'(val);
      REG_BOX_HEIGHT: cfg_height = BOX_W'(val);
      default:        cfg_margin = BOX_W'(val);
    endcase
  endtask

  task automatic set_grid(int unsigned cell_len, int unsigned w, int unsigned h,
                          int unsigned m);
    drain();
    reg_write(REG_CELL_SIZE, cell_len);
    reg_write(REG_BOX_WIDTH, w);
    reg_write(REG_BOX_HEIGHT, h);
    reg_write(REG_MARGIN, m);
  endtask

  // lookup aimed at the built grid, with some spill past every edge
  task automatic aimed_lookup();
    int span_x, span_y;
    span_x = tbl_cols * int'(tbl_cell / 2) / 2 + int'(tbl_cell);
    span_y = tbl_rows * int'(tbl_cell / 2) / 2 + int'(tbl_cell);
    if (!tbl_built || $urandom_range(9) == 0) lookup($urandom, $urandom);
    else lookup(int'($urandom_range(2 * span_x)) - span_x,
                int'($urandom_range(2 * span_y)) - span_y);
  endtask

  // ---------------------------------------------------------------------------
  // Receiver side: random back-pressure, plus a counted hold-off on request
  // ---------------------------------------------------------------------------
  int hold_seen, hold_left;
  always @(posedge clk) begin
    if (rst) begin
      out_ch.ready <= 1'b0;
      hold_seen <= 0;
      hold_left <= 0;
    end else if (hold_seen != hold_requests) begin
      hold_seen <= hold_requests;
      hold_left <= HOLD_CYCLES;
      out_ch.ready <= 1'b0;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
      out_ch.ready <= 1'b0;
    end else begin
      out_ch.ready <= no_idle || ($urandom_range(99) >= 37);
    end
  end

  // result checker: each transfer against the oldest expectation
  always @(posedge clk) begin
    grid_result_t want;
    if (!rst && out_ch.valid && out_ch.ready) begin
      if (pending_results.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result: status %0d distance %0d",
                                       out_ch.status, out_ch.distance);
      end else begin
        want = pending_results.pop_front();
        if (out_ch.status !== want.status || out_ch.distance !== want.distance ||
            out_ch.cells_across !== want.across || out_ch.cells_down !== want.down) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch: status %0d/%0d distance %0d/%0d across %0d/%0d down %0d/%0d",
                     out_ch.status, want.status, out_ch.distance, want.distance,
                     out_ch.cells_across, want.across, out_ch.cells_down, want.down);
        end
      end
    end
  end

  // watchdog: any transfer on either channel or the register port counts as progress
  int quiet_cycles = 0;
  always @(posedge clk) begin
    if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) || (psel && penable))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles == QUIET_LIMIT) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------
  task automatic test_before_build();
    lookup(0, 0);
    lookup(32'h7FFFFF, 32'h800000);
    lookup(32'h800000, 32'h7FFFFF);
  endtask

  // reset config: one empty cell, centre at half a cell; probe every edge
  task automatic test_reset_grid();
    rebuild();
    lookup(0, 0);
    lookup(-255, -1);     // small negatives truncate into cell 0
    lookup(-256, 255);    // x inside cell 0, y past the last cell
    lookup(-512, 0);      // below cell 0
    lookup(256, 0);       // index equal to the count
    lookup(0, -513);
  endtask

  task automatic test_too_large();
    set_grid(0, 0, 0, 0);        // zero cell size
    rebuild();
    lookup(0, 0);
    set_grid(1, 200, 3, 0);      // too many columns
    rebuild();
    set_grid(256, 1000, 32'hFFFFF, 0);  // too many rows
    rebuild();
    set_grid(1, 32'hFFFFF, 32'hFFFFF, 32'hFFFFF);
    rebuild();
    lookup(0, 0);
  endtask

  // largest grid (counts come out odd, so 63 x 63), then lookups at its borders;
  // the width puts the extent remainder exactly at half a cell (zero offset)
  task automatic test_full_grid();
    set_grid(256, 63 * 256, 63 * 256 - 300, 0);
    rebuild();
    lookup(8063, 8063);
    lookup(-8319, -8319);
    lookup(8064, 0);
    lookup(-8320, 100);
    repeat (6) aimed_lookup();
  endtask

  // lookups keep the cell size and centre of the last rebuild
  task automatic test_config_after_build();
    set_grid(65535, 300000, 12345, 99999);
    rebuild();
    set_grid(3, 20, 7, 2);
    repeat (3) aimed_lookup();
    rebuild();               // fine cells with one-unit sampling steps
    repeat (3) aimed_lookup();
    rebuild();               // same config again still rebuilds
    lookup(0, 0);
  endtask

  task automatic random_phase(int items);
    int unsigned cell_len, w, h, m;
    case ($urandom_range(3))
      0: cell_len = $urandom_range(1, 20);
      1: cell_len = $urandom_range(1, 1000);
      default: cell_len = $urandom_range(1, 65535);
    endcase
    w = $urandom_range(0, 10 * cell_len);
    h = $urandom_range(0, 10 * cell_len);
    m = $urandom_range(0, 2 * cell_len);
    if (w > 32'hFFFFF) w = 32'hFFFFF;
    if (h > 32'hFFFFF) h = 32'hFFFFF;
    if ($urandom_range(7) == 0) begin
      w = $urandom_range(0, 32'hFFFFF);   // mostly too large: just the status
      m = $urandom_range(0, 32'hFFFFF);
    end
    set_grid(cell_len, w, h, m);
    rebuild();
    repeat (items) begin
      if ($urandom_range(19) == 0) rebuild();
      else aimed_lookup();
    end
  endtask

  task automatic test_random();
    no_idle = 1'b1;          // first phase runs without any bubbles
    random_phase(60);
    no_idle = 1'b0;
    hold_requests++;         // receiver holds off while earlier results drain
    random_phase(60);
    repeat (6) random_phase(60);
  endtask

  initial begin
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    in_ch.valid = 1'b0;
    in_ch.opcode = OP_LOOKUP;
    in_ch.query_x = '0;
    in_ch.query_y = '0;
    cfg_cell = 256;
    cfg_width = '0;
    cfg_height = '0;
    cfg_margin = '0;
    tbl_built = 1'b0;
    tbl_cols = 0;
    tbl_rows = 0;
    tbl_ctr_x = 0;
    tbl_ctr_y = 0;
    tbl_cell = 0;
    repeat (10) @(posedge clk);
    rst <= 1'b0;

    test_before_build();
    test_reset_grid();
    test_too_large();
    test_full_grid();
    test_config_after_build();
    test_random();

    drain();
    repeat (200) @(posedge clk);
    if (mismatches == 0 && pending_results.size() == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
`default_nettype wire

// ===== files.f =====
src/bdgt_pkg.sv
src/bdgt_in_if.sv
src/bdgt_out_if.sv
src/bdgt_div.sv
src/bdgt_sqrt.sv
src/box_distance_grid_table.sv
test/tb_top.sv
